FILE: src/sorted_list_table_assert.svh
// Assertion macros shared by the sorted list table RTL.
`ifndef SORTED_LIST_TABLE_ASSERT_SVH
`define SORTED_LIST_TABLE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SLT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SLT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/slt_pkg.sv
// Package: sizes, operation codes and status codes of the sorted list table.
`timescale 1ns / 1ps

package slt_pkg;

    localparam int DEPTH    = 16;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int OP_W     = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
    localparam logic [OP_W-1:0] OP_DUMP   = 3'd3;
    localparam logic [OP_W-1:0] OP_DRAIN  = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

endpackage

FILE: src/slt_if.sv
// Interfaces: request and response channels of the sorted list table.
`timescale 1ns / 1ps

interface slt_req_if;
    logic                              valid;
    logic                              ready;
    logic [slt_pkg::OP_W-1:0]          op;
    logic signed [slt_pkg::DATA_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface slt_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [slt_pkg::DATA_W-1:0] element;
    logic [slt_pkg::STATUS_W-1:0]      status;
    logic                              last;

    modport source (output valid, output element, output status, output last, input ready);
    modport sink   (input valid, input element, input status, input last, output ready);
endinterface

FILE: src/sorted_list_table.sv
// Top level: sorted list table with one memory and one compare unit.
//
//  channel | dir | payload                    | handshake
//  --------+-----+----------------------------+-------------
//  req     | in  | op, value                  | valid/ready
//  rsp     | out | element, status, last      | valid/ready
//
// One request at a time; ready is high only while the sequencer is idle.
// Insert walks down from the top, search and delete walk up from slot zero, and
// dump and drain visit every entry and wait on output stalls: every visited
// entry passes through a read state and a compare state on the memory.
// rst_n is asynchronous and empties the table (memory contents are not cleared).
// A stalled response holds in the output register; the sequencer waits on it.
`timescale 1ns / 1ps

module sorted_list_table (
    input  logic      clk,
    input  logic      rst_n,
    slt_req_if.sink   req,
    slt_rsp_if.source rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_PUT,
        S_RESP
    } state_t;

    state_t                             state_reg;
    logic [slt_pkg::OP_W-1:0]           op_reg;
    logic signed [slt_pkg::DATA_W-1:0]  val_reg;
    logic [slt_pkg::ADDR_W-1:0]         addr_reg;
    logic [slt_pkg::CNT_W-1:0]          occ_reg;
    logic [slt_pkg::STATUS_W-1:0]       status_reg;
    logic                               shift_reg;

    logic                               out_valid_reg;
    logic signed [slt_pkg::DATA_W-1:0]  out_element_reg;
    logic [slt_pkg::STATUS_W-1:0]       out_status_reg;
    logic                               out_last_reg;

    // entry storage, one write and one registered read port
    logic signed [slt_pkg::DATA_W-1:0]  mem [slt_pkg::DEPTH];
    logic signed [slt_pkg::DATA_W-1:0]  rd_data_reg;
    logic                               we;
    logic [slt_pkg::ADDR_W-1:0]         wa;
    logic signed [slt_pkg::DATA_W-1:0]  wd;

    logic                               out_free;
    logic                               out_load;
    logic                               at_end;
    logic                               not_less;
    logic                               equal;

    assign req.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.element = out_element_reg;
    assign rsp.status  = out_status_reg;
    assign rsp.last    = out_last_reg;

    assign out_free = !out_valid_reg || rsp.ready;
    assign at_end   = (slt_pkg::CNT_W'(addr_reg) == occ_reg - slt_pkg::CNT_W'(1));

    // output register loads on a single-result reply or on each dump/drain entry
    assign out_load = out_free &&
                      ((state_reg == S_RESP) ||
                       (state_reg == S_CMP &&
                        (op_reg == slt_pkg::OP_DUMP || op_reg == slt_pkg::OP_DRAIN)));

    // shared compare unit
    assign not_less = (rd_data_reg >= val_reg);
    assign equal    = (rd_data_reg == val_reg);

    // memory write selection
    always_comb
    begin
        we = 1'b0;
        wa = addr_reg;
        wd = rd_data_reg;
        if (state_reg == S_CMP && op_reg == slt_pkg::OP_INSERT)
        begin
            we = 1'b1;
            wa = slt_pkg::ADDR_W'(addr_reg + slt_pkg::ADDR_W'(1));
            wd = not_less ? rd_data_reg : val_reg;
        end
        else if (state_reg == S_CMP && op_reg == slt_pkg::OP_DELETE && shift_reg)
        begin
            we = 1'b1;
            wa = slt_pkg::ADDR_W'(addr_reg - slt_pkg::ADDR_W'(1));
        end
        else if (state_reg == S_PUT)
        begin
            we = 1'b1;
            wa = '0;
            wd = val_reg;
        end
    end

    // memory
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_data_reg <= mem[addr_reg];
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            op_reg          <= slt_pkg::OP_INSERT;
            val_reg         <= '0;
            addr_reg        <= '0;
            occ_reg         <= '0;
            status_reg      <= slt_pkg::ST_OK;
            out_valid_reg   <= 1'b0;
            out_element_reg <= '0;
            out_status_reg  <= slt_pkg::ST_OK;
            out_last_reg    <= 1'b0;
            shift_reg       <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        op_reg    <= req.op;
                        val_reg   <= req.value;
                        shift_reg <= 1'b0;
                        addr_reg  <= '0;
                        case (req.op) inside
                            slt_pkg::OP_INSERT:
                            begin
                                if (occ_reg == slt_pkg::CNT_W'(slt_pkg::DEPTH))
                                begin
                                    status_reg <= slt_pkg::ST_FULL;
                                    state_reg  <= S_RESP;
                                end
                                else if (occ_reg == '0)
                                begin
                                    state_reg <= S_PUT;
                                end
                                else
                                begin
                                    addr_reg  <= slt_pkg::ADDR_W'(occ_reg - slt_pkg::CNT_W'(1));
                                    state_reg <= S_READ;
                                end
                            end
                            slt_pkg::OP_SEARCH, slt_pkg::OP_DELETE:
                            begin
                                status_reg <= slt_pkg::ST_MISSING;
                                state_reg  <= (occ_reg == '0) ? S_RESP : S_READ;
                            end
                            slt_pkg::OP_DUMP, slt_pkg::OP_DRAIN:
                            begin
                                status_reg <= slt_pkg::ST_EMPTY;
                                state_reg  <= (occ_reg == '0) ? S_RESP : S_READ;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end

                S_READ:
                begin
                    state_reg <= S_CMP;
                end

                S_CMP:
                begin
                    case (op_reg) inside
                        // walk down from the top, moving entries not less than the value up one slot
                        slt_pkg::OP_INSERT:
                        begin
                            if (!not_less)
                            begin
                                occ_reg    <= occ_reg + slt_pkg::CNT_W'(1);
                                status_reg <= slt_pkg::ST_OK;
                                state_reg  <= S_RESP;
                            end
                            else if (addr_reg == '0)
                            begin
                                state_reg <= S_PUT;
                            end
                            else
                            begin
                                addr_reg  <= slt_pkg::ADDR_W'(addr_reg - slt_pkg::ADDR_W'(1));
                                state_reg <= S_READ;
                            end
                        end
                        slt_pkg::OP_SEARCH:
                        begin
                            if (equal || at_end)
                            begin
                                status_reg <= equal ? slt_pkg::ST_OK : slt_pkg::ST_MISSING;
                                state_reg  <= S_RESP;
                            end
                            else
                            begin
                                addr_reg  <= slt_pkg::ADDR_W'(addr_reg + slt_pkg::ADDR_W'(1));
                                state_reg <= S_READ;
                            end
                        end
                        // find the first match, then pull the rest down one slot
                        slt_pkg::OP_DELETE:
                        begin
                            if ((shift_reg || equal) && at_end)
                            begin
                                occ_reg    <= occ_reg - slt_pkg::CNT_W'(1);
                                status_reg <= slt_pkg::ST_OK;
                                state_reg  <= S_RESP;
                            end
                            else if (at_end)
                            begin
                                status_reg <= slt_pkg::ST_MISSING;
                                state_reg  <= S_RESP;
                            end
                            else
                            begin
                                shift_reg <= shift_reg || equal;
                                addr_reg  <= slt_pkg::ADDR_W'(addr_reg + slt_pkg::ADDR_W'(1));
                                state_reg <= S_READ;
                            end
                        end
                        slt_pkg::OP_DUMP, slt_pkg::OP_DRAIN:
                        begin
                            if (out_free)
                            begin
                                out_element_reg <= rd_data_reg;
                                out_status_reg  <= slt_pkg::ST_OK;
                                out_last_reg    <= at_end;
                                if (at_end)
                                begin
                                    if (op_reg == slt_pkg::OP_DRAIN)
                                    begin
                                        occ_reg <= '0;
                                    end
                                    state_reg <= S_IDLE;
                                end
                                else
                                begin
                                    addr_reg  <= slt_pkg::ADDR_W'(addr_reg + slt_pkg::ADDR_W'(1));
                                    state_reg <= S_READ;
                                end
                            end
                        end
                        default:
                        begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end

                // new value lands in slot zero
                S_PUT:
                begin
                    occ_reg    <= occ_reg + slt_pkg::CNT_W'(1);
                    status_reg <= slt_pkg::ST_OK;
                    state_reg  <= S_RESP;
                end

                // single-result reply
                S_RESP:
                begin
                    if (out_free)
                    begin
                        out_element_reg <= (status_reg == slt_pkg::ST_EMPTY) ? '0 : val_reg;
                        out_status_reg  <= status_reg;
                        out_last_reg    <= 1'b1;
                        state_reg       <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`include "sorted_list_table_assert.svh"

    `SLT_ASSERT_IMP(a_occ_bound, 1'b1, occ_reg <= slt_pkg::CNT_W'(slt_pkg::DEPTH),
                    "occupancy above depth")

    `SLT_ASSERT_NXT(a_idle_occ, state_reg == S_IDLE, $stable(occ_reg),
                    "occupancy moved while idle")

    `SLT_ASSERT_NXT(a_full_flag,
                    req.valid && req.ready && req.op == slt_pkg::OP_INSERT
                        && occ_reg == slt_pkg::CNT_W'(slt_pkg::DEPTH),
                    state_reg == S_RESP && status_reg == slt_pkg::ST_FULL,
                    "full insert not flagged")

    `SLT_ASSERT_NXT(a_drain_clear,
                    state_reg == S_CMP && op_reg == slt_pkg::OP_DRAIN && out_free && at_end,
                    occ_reg == '0 && out_last_reg,
                    "drain did not empty table")

endmodule

FILE: tb/sv/sorted_list_table_test.sv
// Testbench: sorted list table checked against a queue-based model of its contents.
`timescale 1ns / 1ps

module sorted_list_table_test;
    import slt_pkg::*;

    // op codes the block ignores
    localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    localparam int PLAN_LEN   = 19;
    localparam int HOLD_LONG  = 150;
    localparam int TAIL_WAIT  = 60;

    typedef struct packed {
        logic signed [DATA_W-1:0] element;
        logic [STATUS_W-1:0]      status;
        logic                     last;
    } response_t;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] value;
        logic                     typed;
        response_t                want;
    } plan_row_t;

    logic clk;
    logic rst_n;

    slt_req_if req_ch ();
    slt_rsp_if rsp_ch ();

    sorted_list_table uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // our copy of the table contents, kept in ascending order
    logic signed [DATA_W-1:0] sorted_copy[$];
    response_t                expected_responses[$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_left      = 0;

    int mismatch_count = 0;
    int requests_sent  = 0;
    int responses_seen = 0;
    int full_rejects   = 0;
    int peak_fill      = 0;

    response_t head;

    // directed rows; typed expectations only where they are obvious
    plan_row_t directed_plan [0:PLAN_LEN-1] = '{
        '{OP_DUMP,      32'sd0,        1'b1, '{32'sd0,   ST_EMPTY,   1'b1}},
        '{OP_DRAIN,     32'sh12345678, 1'b1, '{32'sd0,   ST_EMPTY,   1'b1}},
        '{OP_DELETE,    32'sd5,        1'b1, '{32'sd5,   ST_MISSING, 1'b1}},
        '{OP_SEARCH,    32'sd0,        1'b1, '{32'sd0,   ST_MISSING, 1'b1}},
        '{OP_INSERT,    VAL_MAX,       1'b1, '{VAL_MAX,  ST_OK,      1'b1}},
        '{OP_INSERT,    VAL_MIN,       1'b1, '{VAL_MIN,  ST_OK,      1'b1}},
        '{OP_INSERT,    32'sd0,        1'b1, '{32'sd0,   ST_OK,      1'b1}},
        '{OP_INSERT,    -32'sd1,       1'b1, '{-32'sd1,  ST_OK,      1'b1}},
        '{OP_INSERT,    32'sd0,        1'b0, '0},
        '{OP_SEARCH,    VAL_MIN,       1'b1, '{VAL_MIN,  ST_OK,      1'b1}},
        '{OP_SEARCH,    32'sd1,        1'b1, '{32'sd1,   ST_MISSING, 1'b1}},
        '{OP_UNUSED_LO, 32'sd9,        1'b0, '0},
        '{OP_UNUSED_HI, -32'sd1,       1'b0, '0},
        '{OP_DUMP,      32'sd0,        1'b0, '0},
        '{OP_DELETE,    32'sd0,        1'b0, '0},
        '{OP_DELETE,    VAL_MAX,       1'b0, '0},
        '{OP_SEARCH,    VAL_MAX,       1'b0, '0},
        '{OP_DRAIN,     32'sd0,        1'b0, '0},
        '{OP_DUMP,      -32'sd1,       1'b1, '{32'sd0,   ST_EMPTY,   1'b1}}
    };

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // timeout guard
    initial
    begin
        #3_000_000;
        $error("timeout: %0d responses still outstanding", expected_responses.size());
        $display("status: fail");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off counted down here
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left = hold_left - 1;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // apply one request to the sorted copy; optionally queue its responses
    task automatic predict_table_op(input logic [OP_W-1:0] op,
                                    input logic signed [DATA_W-1:0] value,
                                    input bit record);
        int        pos;
        int        n;
        bit        hit;
        response_t batch[$];

        case (op)
            OP_INSERT:
            begin
                if (sorted_copy.size() >= DEPTH)
                begin
                    batch.push_back('{value, ST_FULL, 1'b1});
                    full_rejects++;
                end
                else
                begin
                    pos = 0;
                    while (pos < sorted_copy.size() && sorted_copy[pos] < value)
                        pos++;
                    sorted_copy.insert(pos, value);
                    batch.push_back('{value, ST_OK, 1'b1});
                end
            end
            OP_SEARCH:
            begin
                hit = 1'b0;
                foreach (sorted_copy[n])
                    if (sorted_copy[n] == value)
                        hit = 1'b1;
                batch.push_back('{value, hit ? ST_OK : ST_MISSING, 1'b1});
            end
            OP_DELETE:
            begin
                pos = 0;
                while (pos < sorted_copy.size() && sorted_copy[pos] != value)
                    pos++;
                if (pos >= sorted_copy.size())
                begin
                    batch.push_back('{value, ST_MISSING, 1'b1});
                end
                else
                begin
                    sorted_copy.delete(pos);
                    batch.push_back('{value, ST_OK, 1'b1});
                end
            end
            OP_DUMP, OP_DRAIN:
            begin
                if (sorted_copy.size() == 0)
                    batch.push_back('{32'sd0, ST_EMPTY, 1'b1});
                else
                    for (n = 0; n < sorted_copy.size(); n++)
                        batch.push_back('{sorted_copy[n], ST_OK, n == sorted_copy.size() - 1});
                if (op == OP_DRAIN)
                    sorted_copy.delete();
            end
            default:
            begin
                // unused codes: no response, no change
            end
        endcase

        if (sorted_copy.size() > peak_fill)
            peak_fill = sorted_copy.size();
        if (record)
            foreach (batch[n])
                expected_responses.push_back(batch[n]);
    endtask

    // drive one request; called and returns at a falling edge
    task automatic send_request(input logic [OP_W-1:0] op,
                                input logic signed [DATA_W-1:0] value,
                                input bit typed,
                                input response_t want);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.op    <= op;
        req_ch.value <= value;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        requests_sent++;
        predict_table_op(op, value, !typed);
        if (typed)
            expected_responses.push_back(want);
        @(negedge clk);
    endtask

    // sender pause until every outstanding response is back
    task automatic wait_for_responses();
        req_ch.valid <= 1'b0;
        while (expected_responses.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // small values for duplicates and hits, mostly full-range values, some extremes
    function automatic logic signed [DATA_W-1:0] random_value();
        case ($urandom_range(3))
            0:       return $urandom_range(16) - 8;
            1:       return $urandom;
            2:       return $urandom_range(1) ? VAL_MIN + $urandom_range(3)
                                              : VAL_MAX - $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    // search and delete often target a stored value so they hit
    function automatic logic signed [DATA_W-1:0] operand_for(input logic [OP_W-1:0] op);
        if ((op == OP_SEARCH || op == OP_DELETE) && sorted_copy.size() > 0
            && $urandom_range(1))
            return sorted_copy[$urandom_range(sorted_copy.size() - 1)];
        return random_value();
    endfunction

    task automatic random_requests(input int count);
        int              k;
        int              pick;
        logic [OP_W-1:0] op;

        for (k = 0; k < count; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                op = OP_INSERT;
            else if (pick < 58)
                op = OP_SEARCH;
            else if (pick < 78)
                op = OP_DELETE;
            else if (pick < 87)
                op = OP_DUMP;
            else if (pick < 93)
                op = OP_DRAIN;
            else
                op = OP_W'(OP_UNUSED_LO + $urandom_range(2));
            send_request(op, operand_for(op), 1'b0, '0);
        end
    endtask

    // fill to capacity, push past it, then dump, free one slot, refill and drain
    task automatic fill_to_capacity();
        while (sorted_copy.size() < DEPTH)
            send_request(OP_INSERT, random_value(), 1'b0, '0);
        repeat (2)
            send_request(OP_INSERT, random_value(), 1'b0, '0);
        send_request(OP_DUMP, random_value(), 1'b0, '0);
        send_request(OP_DELETE, sorted_copy[$urandom_range(DEPTH - 1)], 1'b0, '0);
        send_request(OP_INSERT, random_value(), 1'b0, '0);
        send_request(OP_DRAIN, random_value(), 1'b0, '0);
    endtask

    // response checking
    task automatic check_field(input string name, input longint expected, input longint actual);
        if (expected != actual)
        begin
            $error("%s: expected %0d, got %0d", name, expected, actual);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_responses.size() == 0)
            begin
                $error("response with none expected: element %0d status %0d last %0d",
                       rsp_ch.element, rsp_ch.status, rsp_ch.last);
                mismatch_count++;
            end
            else
            begin
                head = expected_responses.pop_front();
                check_field("element", head.element, rsp_ch.element);
                check_field("status", head.status, rsp_ch.status);
                check_field("last", head.last, rsp_ch.last);
            end
            responses_seen++;
        end
    end

    // main sequence
    initial
    begin
        int r;

        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.op    = OP_INSERT;
        req_ch.value = '0;
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed rows
        for (r = 0; r < PLAN_LEN; r++)
            send_request(directed_plan[r].op, directed_plan[r].value,
                         directed_plan[r].typed, directed_plan[r].want);

        // no idling; long receiver hold-off while the table fills
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_left      = HOLD_LONG;
        fill_to_capacity();
        random_requests(15);

        wait_for_responses();

        // sender mostly idle
        src_idle_pct   = 78;
        sink_stall_pct = 0;
        random_requests(15);

        // receiver mostly stalled
        src_idle_pct   = 0;
        sink_stall_pct = 78;
        random_requests(15);

        // light idling on both sides
        src_idle_pct   = 13;
        sink_stall_pct = 13;
        random_requests(15);

        wait_for_responses();
        repeat (TAIL_WAIT)
            @(posedge clk);

        $display("covered %0d requests and %0d responses across four idling phases",
                 requests_sent, responses_seen);
        $display("table peaked at %0d of %0d entries, %0d inserts rejected as full",
                 peak_fill, DEPTH, full_rejects);
        if (mismatch_count == 0 && expected_responses.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
